// ===== hdl/eog_pkg.sv =====
// Shared constants and types for the element order generator test block.
`default_nettype none
package eog_pkg;

   // Register indexes on the configuration channel.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_ORDER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_KIND  = 2'd2;

   // Group kinds.
   localparam logic KIND_ADDITIVE       = 1'b0;
   localparam logic KIND_MULTIPLICATIVE = 1'b1;

   // Operations of the serial arithmetic unit.
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_REDUCE = 2'd0;
   localparam logic [OP_W-1:0] OP_MULMOD = 2'd1;
   localparam logic [OP_W-1:0] OP_ADDMOD = 2'd2;

   typedef struct packed {
      logic            start;
      logic [OP_W-1:0] op;
   } eog_cmd_type;

endpackage
`default_nettype wire

// ===== hdl/eog_channels.sv =====
// Channel interfaces for requests, responses and register writes.
`default_nettype none
interface eog_req_if #(parameter int WIDTH = 16);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] element_value;
   modport source (output valid, output element_value, input ready);
   modport sink (input valid, input element_value, output ready);
endinterface

interface eog_rsp_if #(parameter int WIDTH = 16);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] element_order;
   logic             order_found;
   logic             is_generator;
   modport source (output valid, output element_order, output order_found,
                   output is_generator, input ready);
   modport sink (input valid, input element_order, input order_found,
                 input is_generator, output ready);
endinterface

interface eog_csr_if #(parameter int WIDTH = 16, parameter int IDX_W = 2);
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [WIDTH-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/eog_arith.sv =====
// Bit-serial modular arithmetic unit: reduction, multiplication and addition mod n.
`default_nettype none
module eog_arith
   import eog_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire eog_cmd_type      cmd,
   input  wire logic [WIDTH-1:0] operand_a,
   input  wire logic [WIDTH-1:0] operand_b,
   input  wire logic [WIDTH-1:0] modulus,
   output logic [WIDTH-1:0]      result,
   output logic                  done
);
   localparam int CNT_W = $clog2(WIDTH);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIDTH:0]   ext_n;
   logic [WIDTH:0]   dbl;
   logic [WIDTH:0]   red1;
   logic [WIDTH-1:0] addend;
   logic [WIDTH:0]   sum;
   logic [WIDTH:0]   red2;
   logic [WIDTH-1:0] step_val;

   // One bit of the operand per cycle, most significant first: the running
   // value is doubled (shifting in the dividend bit when reducing) and then,
   // when multiplying, the multiplicand is added if the bit is set.
   always_comb begin
      ext_n  = {1'b0, modulus};
      dbl    = {acc_ff, (op_ff == OP_REDUCE) ? shift_ff[WIDTH-1] : 1'b0};
      red1   = (dbl >= ext_n) ? dbl - ext_n : dbl;
      addend = busy_ff ? red1[WIDTH-1:0] : operand_a;
      sum    = {1'b0, addend} + {1'b0, operand_b};
      red2   = (sum >= ext_n) ? sum - ext_n : sum;
      if (op_ff == OP_MULMOD && shift_ff[WIDTH-1]) begin
         step_val = red2[WIDTH-1:0];
      end else begin
         step_val = red1[WIDTH-1:0];
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         if (cmd.op == OP_ADDMOD) begin
            acc_in  = red2[WIDTH-1:0];
            done_in = 1'b1;
         end else begin
            acc_in   = '0;
            shift_in = operand_a;
            cnt_in   = CNT_W'(WIDTH - 1);
            op_in    = cmd.op;
            busy_in  = 1'b1;
         end
      end else if (busy_ff) begin
         acc_in   = step_val;
         shift_in = {shift_ff[WIDTH-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
      op_ff    <= op_in;
   end

   assign result = acc_ff;
   assign done   = done_ff;

endmodule
`default_nettype wire

// ===== hdl/element_order_generator_test.sv =====
// Top level of the element order and generator test block.
// A request carries one element; it is reduced mod the configured modulus
// and its order is searched for by stepping k = 1, 2, ... up to the modulus.
// In a multiplicative group each step multiplies by the element mod n; in an
// additive group each step adds it mod n. One response per request gives
// the order (0 if none), a found flag and whether the order equals the
// configured group order.
// The element is first reduced in the bit-serial unit. Each multiplicative
// step runs through the bit-serial multiplier and each additive step is a
// single modular addition; the running value is checked against the
// identity before each step. A modulus of zero skips the reduction and the
// search and answers with no order. One item is worked on at a time.
// The response is held in an output register, so the next request is taken
// while a finished response waits; a new result waits until the receiver
// takes the old one. Configuration writes are always taken; they must be
// made only while the block is idle, which the block does not enforce.
// Reset sets modulus 2, group order 1 and the multiplicative kind and
// empties the response register.
`default_nettype none
module element_order_generator_test
   import eog_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   eog_req_if.sink   req_chan,
   eog_rsp_if.source rsp_chan,
   eog_csr_if.sink   csr_chan
);
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_STEP   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic [WIDTH-1:0] group_order_ff, group_order_in;
   logic             kind_ff, kind_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] p_ff, p_in;
   logic [WIDTH-1:0] k_ff, k_in;
   logic [WIDTH-1:0] pend_order_ff, pend_order_in;
   logic             pend_found_ff, pend_found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] order_ff, order_in;
   logic             found_ff, found_in;
   logic             gen_ff, gen_in;

   eog_cmd_type      cmd;
   logic [WIDTH-1:0] arith_a;
   logic [WIDTH-1:0] arith_result;
   logic             arith_done;
   logic             req_xfer;
   logic             csr_xfer;
   logic [WIDTH-1:0] ident;
   logic             hit;
   logic             last_k;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_xfer       = csr_chan.valid;

   // The identity is 0 in an additive group and 1 mod n otherwise.
   assign ident  = WIDTH'(kind_ff == KIND_MULTIPLICATIVE && modulus_ff != WIDTH'(1));
   assign hit    = (p_ff == ident);
   assign last_k = (k_ff == modulus_ff);

   always_comb begin
      cmd.start = 1'b0;
      cmd.op    = OP_REDUCE;
      arith_a   = p_ff;
      if (state_ff == ST_IDLE) begin
         arith_a   = req_chan.element_value;
         cmd.start = req_xfer && (modulus_ff != '0);
      end else if (state_ff == ST_CHECK) begin
         cmd.start = !hit && !last_k;
         cmd.op    = (kind_ff == KIND_MULTIPLICATIVE) ? OP_MULMOD : OP_ADDMOD;
      end
   end

   eog_arith #(
      .WIDTH(WIDTH)
   ) u_arith (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .operand_a(arith_a),
      .operand_b(a_ff),
      .modulus  (modulus_ff),
      .result   (arith_result),
      .done     (arith_done)
   );

   always_comb begin
      modulus_in     = modulus_ff;
      group_order_in = group_order_ff;
      kind_in        = kind_ff;
      if (csr_xfer) begin
         unique case (csr_chan.index)
            CSR_MODULUS:     modulus_in     = csr_chan.data;
            CSR_GROUP_ORDER: group_order_in = csr_chan.data;
            CSR_GROUP_KIND:  kind_in        = csr_chan.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      p_in          = p_ff;
      k_in          = k_ff;
      pend_order_in = pend_order_ff;
      pend_found_in = pend_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      order_in      = order_ff;
      found_in      = found_ff;
      gen_in        = gen_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (modulus_ff == '0) begin
                  pend_order_in = '0;
                  pend_found_in = 1'b0;
                  state_in      = ST_FINISH;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (arith_done) begin
               a_in     = arith_result;
               p_in     = arith_result;
               k_in     = WIDTH'(1);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (hit) begin
               pend_order_in = k_ff;
               pend_found_in = 1'b1;
               state_in      = ST_FINISH;
            end else if (last_k) begin
               pend_order_in = '0;
               pend_found_in = 1'b0;
               state_in      = ST_FINISH;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (arith_done) begin
               p_in     = arith_result;
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               order_in     = pend_order_ff;
               found_in     = pend_found_ff;
               gen_in       = pend_found_ff && (pend_order_ff == group_order_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         modulus_ff     <= WIDTH'(2);
         group_order_ff <= WIDTH'(1);
         kind_ff        <= KIND_MULTIPLICATIVE;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         modulus_ff     <= modulus_in;
         group_order_ff <= group_order_in;
         kind_ff        <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      p_ff          <= p_in;
      k_ff          <= k_in;
      pend_order_ff <= pend_order_in;
      pend_found_ff <= pend_found_in;
      order_ff      <= order_in;
      found_ff      <= found_in;
      gen_ff        <= gen_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.element_order = order_ff;
   assign rsp_chan.order_found   = found_ff;
   assign rsp_chan.is_generator  = gen_ff;

   // The arithmetic unit only finishes work that the sequencer waits for.
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      arith_done |-> (state_ff == ST_REDUCE || state_ff == ST_STEP))
      else $error("arithmetic result arrived outside a wait state");

   // The exponent under test stays within 1..n.
   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (k_ff != '0 && k_ff <= modulus_ff))
      else $error("exponent out of range");

   // The running power or multiple is always reduced.
   a_p_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (p_ff < modulus_ff))
      else $error("running value not reduced mod n");

   // A response without an order reports zero and no generator.
   a_no_order_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !found_ff) |-> (order_ff == '0 && !gen_ff))
      else $error("missing order reported with nonzero fields");

   // A search step is entered only from the check state, after the request has been reduced.
   a_step_follows_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && $past(state_ff) != ST_STEP) |-> $past(state_ff) == ST_CHECK)
      else $error("search step entered from wrong state");

endmodule
`default_nettype wire
